### rtl/core/hmt_pkg.sv
// ----------------------------------------------------------------------------
// hmt_pkg
// Shared types and constants of the huffman tree merge engine: command and
// status codes and the input and result item structs.
// ----------------------------------------------------------------------------
package hmt_pkg;

  localparam int unsigned FREQ_W = 40;
  localparam int unsigned LEAF_W = 32;
  localparam int unsigned IDX_W  = 9;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_MERGE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_DONE       = 3'd0,
    ST_COMPLETE   = 3'd1,
    ST_NO_LEAVES  = 3'd2,
    ST_STORE_FULL = 3'd3,
    ST_LOCKED     = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [LEAF_W-1:0] leaf_freq;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [IDX_W-1:0]  branch_index;
    logic [FREQ_W-1:0] branch_freq;
    logic              is_root;
  } out_item_t;

endpackage

### rtl/core/hmt_node_bank.sv
// ----------------------------------------------------------------------------
// hmt_node_bank
// Frequency memory with one write port and two registered read ports. A read
// of the address written at the same edge returns the new data.
// ----------------------------------------------------------------------------
module hmt_node_bank #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q, rd_b_q, byp_q;
  logic             fwd_a_q, fwd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_a_q  <= mem_q[raddr_a_i];
      rd_b_q  <= mem_q[raddr_b_i];
      fwd_a_q <= we_i && (waddr_i == raddr_a_i);
      fwd_b_q <= we_i && (waddr_i == raddr_b_i);
      byp_q   <= wdata_i;
    end
  end

  assign rdata_a_o = fwd_a_q ? byp_q : rd_a_q;
  assign rdata_b_o = fwd_b_q ? byp_q : rd_b_q;

endmodule

### rtl/core/hmt_step.sv
// ----------------------------------------------------------------------------
// hmt_step
// Command logic for one item: picks the two smallest queue heads, forms the
// saturated branch sum and computes the next queue pointers and result.
// ----------------------------------------------------------------------------
module hmt_step #(
  parameter int unsigned MAX_LEAVES = 256
) (
  input  hmt_pkg::in_item_t                     item_i,
  input  logic [$clog2(MAX_LEAVES+1)-1:0]      leaf_total_i,
  input  logic [$clog2(MAX_LEAVES+1)-1:0]      leaf_head_i,
  input  logic [$clog2(MAX_LEAVES+1)-1:0]      br_head_i,
  input  logic [$clog2(MAX_LEAVES+1)-1:0]      br_end_i,
  input  logic                                 started_i,
  input  logic [hmt_pkg::FREQ_W-1:0]           last_sum_i,
  input  logic [hmt_pkg::LEAF_W-1:0]           l0_i,
  input  logic [hmt_pkg::LEAF_W-1:0]           l1_i,
  input  logic [hmt_pkg::FREQ_W-1:0]           b0_i,
  input  logic [hmt_pkg::FREQ_W-1:0]           b1_i,
  output logic [$clog2(MAX_LEAVES+1)-1:0]      leaf_total_o,
  output logic [$clog2(MAX_LEAVES+1)-1:0]      leaf_head_o,
  output logic [$clog2(MAX_LEAVES+1)-1:0]      br_head_o,
  output logic [$clog2(MAX_LEAVES+1)-1:0]      br_end_o,
  output logic                                 started_o,
  output logic                                 leaf_we_o,
  output logic [$clog2(MAX_LEAVES)-1:0]        leaf_waddr_o,
  output logic                                 br_we_o,
  output logic [$clog2(MAX_LEAVES)-1:0]        br_waddr_o,
  output logic [hmt_pkg::FREQ_W-1:0]           br_wdata_o,
  output hmt_pkg::out_item_t                    result_o
);

  localparam int unsigned CW = $clog2(MAX_LEAVES + 1);
  localparam int unsigned AW = $clog2(MAX_LEAVES);
  localparam int unsigned NW = $clog2(2 * MAX_LEAVES);
  localparam int unsigned FW = hmt_pkg::FREQ_W;
  localparam int unsigned IW = hmt_pkg::IDX_W;

  logic [CW-1:0] leaf_rem, br_rem;
  logic          l_has1, l_has2, b_has1, b_has2;
  logic [FW-1:0] l0x, l1x;
  logic          first_leaf, second_leaf;
  logic          sec_l_ok, sec_b_ok;
  logic [FW-1:0] sec_lv, sec_bv, a_val, b_val;
  logic [FW:0]   sum_raw;
  logic [FW-1:0] sum;
  logic [NW-1:0] lh_idx, bh_idx, a_idx, b_idx, root_idx;
  logic          complete, last_merge, one_leaf;
  logic [FW-1:0] root_freq;

  assign leaf_rem = leaf_total_i - leaf_head_i;
  assign br_rem   = br_end_i - br_head_i;
  assign l_has1   = leaf_head_i < leaf_total_i;
  assign l_has2   = l_has1 && (leaf_rem > CW'(1));
  assign b_has1   = br_head_i < br_end_i;
  assign b_has2   = b_has1 && (br_rem > CW'(1));
  assign l0x      = FW'(l0_i);
  assign l1x      = FW'(l1_i);

  // leaf queue wins ties
  assign first_leaf  = l_has1 && (!b_has1 || (l0x <= b0_i));
  assign sec_l_ok    = first_leaf ? l_has2 : l_has1;
  assign sec_lv      = first_leaf ? l1x : l0x;
  assign sec_b_ok    = first_leaf ? b_has1 : b_has2;
  assign sec_bv      = first_leaf ? b0_i : b1_i;
  assign second_leaf = sec_l_ok && (!sec_b_ok || (sec_lv <= sec_bv));

  assign a_val   = first_leaf ? l0x : b0_i;
  assign b_val   = second_leaf ? sec_lv : sec_bv;
  assign sum_raw = {1'b0, a_val} + {1'b0, b_val};
  assign sum     = sum_raw[FW] ? {FW{1'b1}} : sum_raw[FW-1:0];

  assign lh_idx = NW'(leaf_head_i);
  assign bh_idx = NW'(leaf_total_i) + NW'(br_head_i);
  assign a_idx  = first_leaf ? lh_idx : bh_idx;
  always_comb begin
    if (second_leaf) begin
      b_idx = first_leaf ? (lh_idx + NW'(1)) : lh_idx;
    end else begin
      b_idx = first_leaf ? bh_idx : (bh_idx + NW'(1));
    end
  end

  // branch pointers are kept relative to the first branch slot
  assign one_leaf   = leaf_total_i == CW'(1);
  assign complete   = br_end_i >= (leaf_total_i - CW'(1));
  assign last_merge = br_end_i == (leaf_total_i - CW'(2));
  assign root_idx   = one_leaf ? '0 : (NW'(leaf_total_i) + NW'(br_end_i) - NW'(1));
  assign root_freq  = one_leaf ? l0x : last_sum_i;

  always_comb begin
    leaf_total_o = leaf_total_i;
    leaf_head_o  = leaf_head_i;
    br_head_o    = br_head_i;
    br_end_o     = br_end_i;
    started_o    = started_i;
    leaf_we_o    = 1'b0;
    leaf_waddr_o = AW'(leaf_total_i);
    br_we_o      = 1'b0;
    br_waddr_o   = AW'(br_end_i);
    br_wdata_o   = sum;
    result_o     = '0;
    result_o.status = hmt_pkg::ST_DONE;
    case (item_i.cmd)
      hmt_pkg::CMD_LOAD: begin
        if (started_i) begin
          result_o.status = hmt_pkg::ST_LOCKED;
        end else if (leaf_total_i >= CW'(MAX_LEAVES)) begin
          result_o.status = hmt_pkg::ST_STORE_FULL;
        end else begin
          leaf_we_o    = 1'b1;
          leaf_total_o = leaf_total_i + CW'(1);
        end
      end
      hmt_pkg::CMD_MERGE: begin
        if (leaf_total_i == '0) begin
          result_o.status = hmt_pkg::ST_NO_LEAVES;
        end else begin
          started_o = 1'b1;
          if (complete) begin
            result_o.status       = hmt_pkg::ST_COMPLETE;
            result_o.branch_index = IW'(root_idx);
            result_o.branch_freq  = root_freq;
          end else begin
            br_we_o               = 1'b1;
            leaf_head_o           = leaf_head_i + CW'(first_leaf) + CW'(second_leaf);
            br_head_o             = br_head_i + CW'(!first_leaf) + CW'(!second_leaf);
            br_end_o              = br_end_i + CW'(1);
            result_o.left_child   = IW'(a_idx);
            result_o.right_child  = IW'(b_idx);
            result_o.branch_index = IW'(NW'(leaf_total_i) + NW'(br_end_i));
            result_o.branch_freq  = sum;
            result_o.is_root      = last_merge;
          end
        end
      end
      hmt_pkg::CMD_CLEAR: begin
        leaf_total_o = '0;
        leaf_head_o  = '0;
        br_head_o    = '0;
        br_end_o     = '0;
        started_o    = 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/huffman_tree_merge_engine.sv
// The transfer edge fills the input register, and the result register loads from
// it as soon as the result register is free.
// Throughput: one item per cycle while the output is free; queue head reads go
// through the registered node banks, addressed with the last item's pointers.
// Reset clears the queue pointers, leaf count and valid flags at once; the node
// banks are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// huffman_tree_merge_engine
// Two-queue huffman tree builder: leaf loads, merge steps and clear, with leaf
// and branch frequency banks and a registered result stage.
// ----------------------------------------------------------------------------
module huffman_tree_merge_engine #(
  parameter int unsigned MAX_LEAVES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hmt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hmt_pkg::out_item_t  out_data_o
);

  localparam int unsigned CW = $clog2(MAX_LEAVES + 1);
  localparam int unsigned AW = $clog2(MAX_LEAVES);
  localparam int unsigned FW = hmt_pkg::FREQ_W;
  localparam int unsigned LW = hmt_pkg::LEAF_W;

  hmt_pkg::in_item_t  in_q;
  logic               in_vld_q, out_vld_q;
  hmt_pkg::out_item_t out_q, result;

  logic [CW-1:0] leaf_total_q, leaf_head_q, br_head_q, br_end_q;
  logic [CW-1:0] leaf_total_d, leaf_head_d, br_head_d, br_end_d;
  logic [CW-1:0] lh_rd, bh_rd;
  logic          started_q, started_d;
  logic [FW-1:0] last_sum_q;

  logic          leaf_we, br_we;
  logic [AW-1:0] leaf_waddr, br_waddr;
  logic [FW-1:0] br_wdata;
  logic [LW-1:0] l0, l1;
  logic [FW-1:0] b0, b1;

  logic in_xfer, adv;

  assign adv        = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // heads are read with the pointers left by the item now retiring
  assign lh_rd = adv ? leaf_head_d : leaf_head_q;
  assign bh_rd = adv ? br_head_d : br_head_q;

  hmt_node_bank #(
    .DEPTH (MAX_LEAVES),
    .WIDTH (LW)
  ) u_leaf_bank (
    .clk_i     (clk_i),
    .we_i      (adv && leaf_we),
    .waddr_i   (leaf_waddr),
    .wdata_i   (in_q.leaf_freq),
    .re_i      (in_xfer),
    .raddr_a_i (AW'(lh_rd)),
    .raddr_b_i (AW'(lh_rd + CW'(1))),
    .rdata_a_o (l0),
    .rdata_b_o (l1)
  );

  hmt_node_bank #(
    .DEPTH (MAX_LEAVES),
    .WIDTH (FW)
  ) u_branch_bank (
    .clk_i     (clk_i),
    .we_i      (adv && br_we),
    .waddr_i   (br_waddr),
    .wdata_i   (br_wdata),
    .re_i      (in_xfer),
    .raddr_a_i (AW'(bh_rd)),
    .raddr_b_i (AW'(bh_rd + CW'(1))),
    .rdata_a_o (b0),
    .rdata_b_o (b1)
  );

  hmt_step #(
    .MAX_LEAVES (MAX_LEAVES)
  ) u_step (
    .item_i       (in_q),
    .leaf_total_i (leaf_total_q),
    .leaf_head_i  (leaf_head_q),
    .br_head_i    (br_head_q),
    .br_end_i     (br_end_q),
    .started_i    (started_q),
    .last_sum_i   (last_sum_q),
    .l0_i         (l0),
    .l1_i         (l1),
    .b0_i         (b0),
    .b1_i         (b1),
    .leaf_total_o (leaf_total_d),
    .leaf_head_o  (leaf_head_d),
    .br_head_o    (br_head_d),
    .br_end_o     (br_end_d),
    .started_o    (started_d),
    .leaf_we_o    (leaf_we),
    .leaf_waddr_o (leaf_waddr),
    .br_we_o      (br_we),
    .br_waddr_o   (br_waddr),
    .br_wdata_o   (br_wdata),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      leaf_total_q <= '0;
      leaf_head_q  <= '0;
      br_head_q    <= '0;
      br_end_q     <= '0;
      started_q    <= 1'b0;
    end else begin
      if (in_xfer) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q    <= 1'b1;
        leaf_total_q <= leaf_total_d;
        leaf_head_q  <= leaf_head_d;
        br_head_q    <= br_head_d;
        br_end_q     <= br_end_d;
        started_q    <= started_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_data_i;
    end
    if (adv) begin
      out_q <= result;
    end
    // newest branch is the root once the tree is complete
    if (adv && br_we) begin
      last_sum_q <= br_wdata;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/hmt_checker.sv
// ----------------------------------------------------------------------------
// hmt_checker
// Port-level checks of the huffman tree merge engine, bound to the top level.
// ----------------------------------------------------------------------------
module hmt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_i,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input hmt_pkg::out_item_t out_data_i
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  // input side only stalls when the result register is occupied
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_i |-> out_valid_i)
    else $error("input stalled with empty result register");

  // root flag only on a successful merge
  a_root_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.is_root |-> out_data_i.status == hmt_pkg::ST_DONE)
    else $error("root flag with non-done status");

  // children are reported only by a merge that took place
  a_child_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.status != hmt_pkg::ST_DONE
      |-> out_data_i.left_child == '0 && out_data_i.right_child == '0)
    else $error("child index on a refused or complete step");

endmodule

bind huffman_tree_merge_engine hmt_checker u_hmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);
